@@ design/crpe_pkg.sv @@
package crpe_pkg;

    // Field widths of the Q16.16 coordinates and the unsigned Q1.16 curve parameter
    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_WIDTH     = T_FRAC_BITS + 1;

    // Doubled coefficients and Horner accumulators stay within 50 * 2^(COORD_WIDTH-1)
    localparam int ACC_WIDTH   = COORD_WIDTH + 6;
    localparam int PROD_WIDTH  = ACC_WIDTH + T_WIDTH;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;
    typedef logic [T_WIDTH-1:0]          tpar_t;

    // t of exactly 1.0
    localparam tpar_t T_ONE = tpar_t'(1) << T_FRAC_BITS;

    // Saturation limits of a signed coordinate
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [T_WIDTH-1:0]            param_t;
        logic signed [COORD_WIDTH-1:0] ctrl_a;
        logic signed [COORD_WIDTH-1:0] ctrl_b;
        logic signed [COORD_WIDTH-1:0] ctrl_c;
        logic signed [COORD_WIDTH-1:0] ctrl_d;
    } crpe_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] position;
        logic signed [COORD_WIDTH-1:0] tangent;
    } crpe_out_t;

endpackage

@@ design/catmull_rom_point_eval.sv @@
// Uniform Catmull-Rom segment evaluator, one coordinate axis per transfer: send three
// transfers (x, y, z) per point. busy stays low, so a transfer is taken every cycle that
// start is high, and each result appears on result with done high for one cycle only,
// once it has passed the coefficient stage, three Horner steps of two stages each
// (multiply by t, then round and add), and the halve-and-saturate output register; the
// receiver cannot hold it off and must capture it then. param_t above 1.0 is clamped to
// 1.0; position and tangent saturate to the signed Q16.16 range.
module catmull_rom_point_eval
    import crpe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  crpe_in_t  sample,
    output logic      done,
    output crpe_out_t result
);

    localparam int PIPE_DEPTH = 8;

    // Halve with rounding to nearest (ties away from zero), then saturate
    function automatic logic [COORD_WIDTH-1:0] sat_half(input acc_t g);
        logic [ACC_WIDTH-1:0] mag;
        logic [ACC_WIDTH-1:0] half;
        logic [ACC_WIDTH-1:0] neg_half;
        logic [COORD_WIDTH-1:0] res;
        mag      = g[ACC_WIDTH-1] ? ACC_WIDTH'(unsigned'(-g)) : ACC_WIDTH'(unsigned'(g));
        half     = (mag + ACC_WIDTH'(1)) >> 1;
        neg_half = ACC_WIDTH'(0) - half;
        if (g[ACC_WIDTH-1])
        begin
            res = (half > ACC_WIDTH'(COORD_MIN)) ? COORD_MIN : neg_half[COORD_WIDTH-1:0];
        end
        else
        begin
            res = (half > ACC_WIDTH'(COORD_MAX)) ? COORD_MAX : half[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    logic                  accept;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;

    acc_t  p0, p1, p2, p3;
    acc_t  a0_next, a1_next, a2_next, a3_next, ta0_next, ta1_next;
    tpar_t t_next;

    acc_t  a0_reg, a1_reg, a2_reg, a3_reg, ta0_reg, ta1_reg;
    tpar_t t_reg;
    acc_t  a2_d1_reg, a2_d2_reg;
    acc_t  a3_d1_reg, a3_d2_reg, a3_d3_reg, a3_d4_reg;

    acc_t  h1, h2, h3, g1, g2;
    tpar_t t1, t2, t3, tg1, tg2;
    acc_t  g2_d1_reg, g2_d2_reg;

    crpe_out_t result_reg;
    crpe_out_t result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Advance the valid bits with the data
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Clamp t and form the doubled basis coefficients
    always_comb
    begin
        t_next   = (sample.param_t > T_ONE) ? T_ONE : sample.param_t;
        p0       = ACC_WIDTH'(sample.ctrl_a);
        p1       = ACC_WIDTH'(sample.ctrl_b);
        p2       = ACC_WIDTH'(sample.ctrl_c);
        p3       = ACC_WIDTH'(sample.ctrl_d);
        a0_next  = p3 - p0 + ((p1 - p2) <<< 1) + (p1 - p2);
        a1_next  = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        a2_next  = p2 - p0;
        a3_next  = p1 <<< 1;
        ta0_next = (a0_next <<< 1) + a0_next;
        ta1_next = a1_next <<< 1;
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        a0_reg  <= a0_next;
        a1_reg  <= a1_next;
        a2_reg  <= a2_next;
        a3_reg  <= a3_next;
        ta0_reg <= ta0_next;
        ta1_reg <= ta1_next;
    end

    // Hold the later coefficients until their Horner step comes up
    always_ff @(posedge clk)
    begin
        a2_d1_reg <= a2_reg;
        a2_d2_reg <= a2_d1_reg;
        a3_d1_reg <= a3_reg;
        a3_d2_reg <= a3_d1_reg;
        a3_d3_reg <= a3_d2_reg;
        a3_d4_reg <= a3_d3_reg;
    end

    // Position: a0*t^3 + a1*t^2 + a2*t + a3
    crpe_horner_step u_pos_step1 (
        .clk    (clk),
        .acc    (a0_reg),
        .t_in   (t_reg),
        .addend (a1_reg),
        .sum    (h1),
        .t_out  (t1)
    );

    crpe_horner_step u_pos_step2 (
        .clk    (clk),
        .acc    (h1),
        .t_in   (t1),
        .addend (a2_d2_reg),
        .sum    (h2),
        .t_out  (t2)
    );

    crpe_horner_step u_pos_step3 (
        .clk    (clk),
        .acc    (h2),
        .t_in   (t2),
        .addend (a3_d4_reg),
        .sum    (h3),
        .t_out  (t3)
    );

    // Tangent: 3*a0*t^2 + 2*a1*t + a2
    crpe_horner_step u_tan_step1 (
        .clk    (clk),
        .acc    (ta0_reg),
        .t_in   (t_reg),
        .addend (ta1_reg),
        .sum    (g1),
        .t_out  (tg1)
    );

    crpe_horner_step u_tan_step2 (
        .clk    (clk),
        .acc    (g1),
        .t_in   (tg1),
        .addend (a2_d2_reg),
        .sum    (g2),
        .t_out  (tg2)
    );

    // Delay the tangent to line up with the last position step
    always_ff @(posedge clk)
    begin
        g2_d1_reg <= g2;
        g2_d2_reg <= g2_d1_reg;
    end

    // Halve, saturate and register the result
    always_comb
    begin
        result_next.position = sat_half(h3);
        result_next.tangent  = sat_half(g2_d2_reg);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = valid_reg[PIPE_DEPTH-1];
    assign result = result_reg;

    // Every transfer in yields one result
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_DEPTH done)
        else $error("accepted transfer produced no result");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, PIPE_DEPTH))
        else $error("result without a matching input transfer");

    // All-zero control values give a zero position and tangent
    a_zero_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.ctrl_a == 0 && sample.ctrl_b == 0 &&
         sample.ctrl_c == 0 && sample.ctrl_d == 0)
        |-> ##PIPE_DEPTH (result.position == 0 && result.tangent == 0))
        else $error("nonzero result from zero control values");

    // At t of zero the curve sits on the second control value
    a_t_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.param_t == 0)
        |-> ##PIPE_DEPTH (result.position == $past(sample.ctrl_b, PIPE_DEPTH)))
        else $error("position at t of zero differs from the second control value");

    // The clamped t leaving the last position step never exceeds 1.0
    a_pos_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[PIPE_DEPTH-2] |-> (t3 <= T_ONE))
        else $error("t past the last position step exceeds 1.0");

    // The clamped t leaving the last tangent step never exceeds 1.0
    a_tan_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (tg2 <= T_ONE))
        else $error("t past the last tangent step exceeds 1.0");

endmodule

@@ design/crpe_horner_step.sv @@
module crpe_horner_step
    import crpe_pkg::*;
(
    input  logic  clk,
    input  acc_t  acc,
    input  tpar_t t_in,
    input  acc_t  addend,
    output acc_t  sum,
    output tpar_t t_out
);

    localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (T_FRAC_BITS - 1);

    logic [ACC_WIDTH-1:0]  mag;
    logic [PROD_WIDTH-1:0] prod_next;
    logic [PROD_WIDTH-1:0] prod_reg;
    logic                  neg_reg;
    acc_t                  addend_reg;
    tpar_t                 t_a_reg;
    logic [PROD_WIDTH-1:0] rnd_full;
    acc_t                  scaled;
    acc_t                  sum_next;
    acc_t                  sum_reg;
    tpar_t                 t_b_reg;

    // Take the magnitude and multiply by t
    always_comb
    begin
        mag       = acc[ACC_WIDTH-1] ? ACC_WIDTH'(unsigned'(-acc)) : ACC_WIDTH'(unsigned'(acc));
        prod_next = PROD_WIDTH'(mag) * PROD_WIDTH'(t_in);
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        neg_reg    <= acc[ACC_WIDTH-1];
        addend_reg <= addend;
        t_a_reg    <= t_in;
    end

    // Round to nearest (ties away from zero), restore the sign, add the next coefficient
    always_comb
    begin
        rnd_full = (prod_reg + ROUND_HALF) >> T_FRAC_BITS;
        scaled   = signed'(rnd_full[ACC_WIDTH-1:0]);
        sum_next = (neg_reg ? -scaled : scaled) + addend_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        t_b_reg <= t_a_reg;
    end

    assign sum   = sum_reg;
    assign t_out = t_b_reg;

endmodule

@@ sim/catmull_rom_point_eval_tb.sv @@
`timescale 1ns / 1ps

module catmull_rom_point_eval_tb;
    import crpe_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // One row of the directed stimulus table
    typedef struct {
        crpe_in_t  stim;
        bit        typed;
        crpe_out_t want;
    } curve_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    crpe_in_t  sample;
    logic      done;
    crpe_out_t result;

    crpe_out_t  pending_points[$];
    curve_row_t curve_table[$];
    int         fail_count;
    int         checked_count;
    int         sent_count;
    int         clamped_count;

    catmull_rom_point_eval DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .sample (sample),
        .done   (done),
        .result (result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run
    initial
    begin
        #5ms;
        $display("Timeout waiting for curve results");
        $display("Some tests failed");
        $finish;
    end

    // round(v * t / 2^T_FRAC_BITS), ties away from zero
    function automatic longint scale_by_t(input longint v, input longint unsigned t);
        longint unsigned mag;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        mag = (mag * t + (64'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Halve a doubled accumulator with rounding, then clip to the coordinate range
    function automatic coord_t halve_and_saturate(input longint acc);
        longint unsigned mag;
        longint unsigned half;
        longint unsigned lim;
        lim  = 64'd1 << (COORD_WIDTH - 1);
        mag  = (acc < 0) ? longint'(-acc) : longint'(acc);
        half = (mag + 64'd1) >> 1;
        if (acc < 0)
            return (half > lim) ? coord_t'(COORD_MIN) : coord_t'(-longint'(half));
        else
            return (half >= lim) ? coord_t'(COORD_MAX) : coord_t'(half);
    endfunction

    // Expected position and tangent for one axis of a segment
    function automatic crpe_out_t eval_segment(input crpe_in_t s);
        longint unsigned t;
        longint p0, p1, p2, p3;
        longint cub, quad, lin, cst;
        longint pos_acc, tan_acc;
        crpe_out_t r;
        t = s.param_t;
        if (t > T_ONE)
            t = T_ONE;
        p0 = longint'($signed(s.ctrl_a));
        p1 = longint'($signed(s.ctrl_b));
        p2 = longint'($signed(s.ctrl_c));
        p3 = longint'($signed(s.ctrl_d));
        // Doubled Catmull-Rom basis keeps every coefficient integral
        cub  = -p0 + 3 * p1 - 3 * p2 + p3;
        quad = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        lin  = -p0 + p2;
        cst  = 2 * p1;
        pos_acc = scale_by_t(cub, t) + quad;
        pos_acc = scale_by_t(pos_acc, t) + lin;
        pos_acc = scale_by_t(pos_acc, t) + cst;
        tan_acc = scale_by_t(3 * cub, t) + 2 * quad;
        tan_acc = scale_by_t(tan_acc, t) + lin;
        r.position = halve_and_saturate(pos_acc);
        r.tangent  = halve_and_saturate(tan_acc);
        return r;
    endfunction

    function automatic coord_t random_coord();
        int v;
        case ($urandom_range(0, 9))
            0: return coord_t'(COORD_MAX);
            1: return coord_t'(COORD_MIN);
            2, 3, 4:
            begin
                v = $urandom_range(0, 1048575);
                return coord_t'(v - 524288);
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic tpar_t random_param_t();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return T_ONE;
            2, 3: return tpar_t'($urandom_range(int'(T_ONE) + 1, 2 * int'(T_ONE) - 1));
            default: return tpar_t'($urandom_range(0, int'(T_ONE)));
        endcase
    endfunction

    task automatic add_row(input tpar_t t, input coord_t a, input coord_t b, input coord_t c,
                           input coord_t d, input bit typed, input coord_t pos,
                           input coord_t tan);
        curve_row_t row;
        row.stim.param_t   = t;
        row.stim.ctrl_a    = a;
        row.stim.ctrl_b    = b;
        row.stim.ctrl_c    = c;
        row.stim.ctrl_d    = d;
        row.typed          = typed;
        row.want.position  = pos;
        row.want.tangent   = tan;
        curve_table.push_back(row);
    endtask

    // Present one sample after an idle gap, hold it until the transfer, queue its result
    task automatic send_sample(input crpe_in_t s, input crpe_out_t want, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start  <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_points.push_back(want);
        sent_count++;
        if (s.param_t > T_ONE)
            clamped_count++;
    endtask

    // Compare each result against the oldest expectation
    always @(posedge clk)
    begin
        crpe_out_t want;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected result: position %0d tangent %0d",
                       $signed(result.position), $signed(result.tangent));
                fail_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                checked_count++;
                if (result.position !== want.position)
                begin
                    $error("position mismatch: expected %0d, actual %0d",
                           $signed(want.position), $signed(result.position));
                    fail_count++;
                end
                if (result.tangent !== want.tangent)
                begin
                    $error("tangent mismatch: expected %0d, actual %0d",
                           $signed(want.tangent), $signed(result.tangent));
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        crpe_in_t  s;
        crpe_out_t want;
        tpar_t     t;
        bit        burst;
        int        gap;
        coord_t    same;

        fail_count    = 0;
        checked_count = 0;
        sent_count    = 0;
        clamped_count = 0;
        burst         = 1'b0;
        start         = 1'b0;
        sample        = '0;
        rst_n         = 1'b0;

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: endpoints, clamping, constant curves, saturation
        add_row('0, '0, '0, '0, '0, 1'b1, '0, '0);
        add_row('0, '0, 32'h0001_0000, 32'h0004_0000, '0, 1'b1, 32'h0001_0000, 32'h0002_0000);
        add_row(T_ONE, '0, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, 1'b1,
                32'h0003_0000, 32'h0002_0000);
        add_row(17'h1FFFF, '0, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, 1'b1,
                32'h0003_0000, 32'h0002_0000);
        add_row(17'h10001, '0, 32'h0001_0000, 32'h0003_0000, 32'h0005_0000, 1'b1,
                32'h0003_0000, 32'h0002_0000);
        add_row('0, COORD_MIN, COORD_MAX, COORD_MAX, '0, 1'b1, COORD_MAX, COORD_MAX);
        add_row(T_ONE, 32'h1234_5678, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1,
                COORD_MIN, COORD_MIN);
        add_row(17'h08000, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, COORD_MAX, '0);
        add_row(17'h04000, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, COORD_MIN, '0);
        add_row(17'h08000, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, '0, '0);
        add_row(17'h08000, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, '0, '0);
        add_row(17'h00001, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, '0, '0);
        add_row(17'h0FFFF, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, '0, '0);
        add_row(17'h0AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                1'b0, '0, '0);
        add_row(17'h15555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                1'b0, '0, '0);
        add_row(17'h04000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                1'b0, '0, '0);
        add_row(17'h0C000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0007_8000,
                1'b0, '0, '0);
        add_row(17'h00003, 32'h0000_0001, 32'h0000_0003, 32'h0000_0002, 32'hFFFF_FFFF,
                1'b0, '0, '0);

        foreach (curve_table[i])
        begin
            want = curve_table[i].typed ? curve_table[i].want
                                        : eval_segment(curve_table[i].stim);
            gap  = (i < 6) ? 0 : $urandom_range(0, 12);
            send_sample(curve_table[i].stim, want, gap);
        end

        // Random points: three axes per point sharing one t, with bursts of back-to-back
        for (int pt = 0; pt < 128; pt++)
        begin
            if ($urandom_range(0, 7) == 0)
                burst = !burst;
            t = random_param_t();
            for (int axis = 0; axis < 3; axis++)
            begin
                s.param_t = t;
                if ($urandom_range(0, 15) == 0)
                begin
                    same     = random_coord();
                    s.ctrl_a = same;
                    s.ctrl_b = same;
                    s.ctrl_c = same;
                    s.ctrl_d = same;
                end
                else
                begin
                    s.ctrl_a = random_coord();
                    s.ctrl_b = random_coord();
                    s.ctrl_c = random_coord();
                    s.ctrl_d = random_coord();
                end
                gap = burst ? 0 : $urandom_range(0, 12);
                send_sample(s, eval_segment(s), gap);
            end
        end

        // Drop start and drain the pipeline before reporting
        @(negedge clk);
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d axis samples (%0d from the directed table), %0d with t above 1.0",
                 sent_count, curve_table.size(), clamped_count);
        $display("Checked %0d position/tangent results", checked_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
